// File: rtl/tsd_pkg.sv
// ----------------------------------------------------------------------------
// tsd_pkg
// shared types, constants and the byte-wide crc-8 step for the scratchpad
// decoder
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int unsigned FRAME_LEN = 9;
	localparam int unsigned CRC_LEN   = 8;
	localparam int unsigned CNT_W     = 4;

	localparam logic [7:0] CRC_POLY   = 8'h8C;
	localparam logic [7:0] EXT_COUNT  = 8'h10;
	localparam logic [15:0] EXT_MASK  = 16'hFFF0;
	localparam logic [15:0] EXT_BASE  = 16'd12;

	// resolution codes, bits 6..5 of the configuration byte
	localparam logic [1:0] RES_9BIT  = 2'b00;
	localparam logic [1:0] RES_10BIT = 2'b01;
	localparam logic [1:0] RES_11BIT = 2'b10;
	localparam logic [1:0] RES_12BIT = 2'b11;

	// result status codes
	localparam logic [1:0] ST_CRC_ERR   = 2'd0;
	localparam logic [1:0] ST_UNCHANGED = 2'd1;
	localparam logic [1:0] ST_REPORTED  = 2'd2;

	// register indexes
	localparam logic CFG_FAMILY    = 1'b0;
	localparam logic CFG_THRESHOLD = 1'b1;

	localparam logic [7:0] THRESHOLD_RESET = 8'd8;

	typedef logic [CNT_W-1:0] count_t;

	// frame status handed from the byte tracker to the decoder
	typedef struct packed {
		logic       result;
		logic       crc_ok;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b4;
		logic [7:0] b6;
		logic [7:0] b7;
	} frame_t;

	// reflected dallas crc-8, one byte, lsb first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
	                                           input logic [7:0] data_in);
		logic [7:0] crc;
		logic [7:0] d;
		logic       mix;
		crc = crc_in;
		d   = data_in;
		for (int i = 0; i < 8; i++) begin
			mix = crc[0] ^ d[0];
			crc = crc >> 1;
			if (mix) begin
				crc = crc ^ CRC_POLY;
			end
			d = d >> 1;
		end
		return crc;
	endfunction

endpackage

// File: rtl/tsd_frame.sv
// ----------------------------------------------------------------------------
// tsd_frame
// byte position, running crc and the scratchpad bytes needed for decoding
// ----------------------------------------------------------------------------
module tsd_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                frame_start,
	output tsd_pkg::frame_t     frame
);

	tsd_pkg::count_t cnt_q;
	logic [7:0]      crc_q;
	logic [7:0]      b0_q, b1_q, b4_q, b6_q, b7_q;

	tsd_pkg::count_t cnt_eff;
	logic [7:0]      crc_eff;
	logic            active;
	logic            in_crc;

	always_comb begin
		cnt_eff = frame_start ? '0 : cnt_q;
		crc_eff = frame_start ? 8'h00 : crc_q;
		active  = cnt_eff < tsd_pkg::count_t'(tsd_pkg::FRAME_LEN);
		in_crc  = cnt_eff < tsd_pkg::count_t'(tsd_pkg::CRC_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= 8'h00;
		end else if (step && active) begin
			cnt_q <= cnt_eff + tsd_pkg::count_t'(1);
			crc_q <= in_crc ? tsd_pkg::crc8_update(crc_eff, data_byte) : crc_eff;
		end
	end

	// only bytes 0, 1, 4, 6 and 7 feed the decode
	always_ff @(posedge clk) begin
		if (step && active) begin
			if (cnt_eff == tsd_pkg::count_t'(0)) b0_q <= data_byte;
			if (cnt_eff == tsd_pkg::count_t'(1)) b1_q <= data_byte;
			if (cnt_eff == tsd_pkg::count_t'(4)) b4_q <= data_byte;
			if (cnt_eff == tsd_pkg::count_t'(6)) b6_q <= data_byte;
			if (cnt_eff == tsd_pkg::count_t'(7)) b7_q <= data_byte;
		end
	end

	always_comb begin
		frame.result = active && !in_crc;
		frame.crc_ok = crc_eff == data_byte;
		frame.b0     = b0_q;
		frame.b1     = b1_q;
		frame.b4     = b4_q;
		frame.b6     = b6_q;
		frame.b7     = b7_q;
	end

endmodule

// File: rtl/tsd_decode.sv
// ----------------------------------------------------------------------------
// tsd_decode
// temperature decode, change threshold test and last reported value
// ----------------------------------------------------------------------------
module tsd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  tsd_pkg::frame_t     frame,
	input  logic                sensor_family,
	input  logic [7:0]          change_threshold,
	output logic [1:0]          status,
	output logic signed [15:0]  temperature,
	output logic signed [15:0]  reported_temperature
);

	logic [15:0] last_q;
	logic [15:0] raw;
	logic [15:0] shifted;
	logic [15:0] dec;
	logic [16:0] diff;
	logic [16:0] mag;
	logic        over;
	logic        report;

	always_comb begin
		raw     = {frame.b1, frame.b0};
		shifted = raw << 3;
		dec     = raw;
		if (sensor_family) begin
			if (frame.b7 == tsd_pkg::EXT_COUNT) begin
				dec = (shifted & tsd_pkg::EXT_MASK) + tsd_pkg::EXT_BASE - {8'h00, frame.b6};
			end else begin
				dec = shifted;
			end
		end else begin
			unique case (frame.b4[6:5])
				tsd_pkg::RES_9BIT:  dec = {raw[15:3], 3'b000};
				tsd_pkg::RES_10BIT: dec = {raw[15:2], 2'b00};
				tsd_pkg::RES_11BIT: dec = {raw[15:1], 1'b0};
				tsd_pkg::RES_12BIT: dec = raw;
			endcase
		end

		diff   = {dec[15], dec} - {last_q[15], last_q};
		mag    = diff[16] ? (17'd0 - diff) : diff;
		over   = mag > {9'd0, change_threshold};
		report = frame.crc_ok && over;

		if (!frame.crc_ok) begin
			status      = tsd_pkg::ST_CRC_ERR;
			temperature = '0;
		end else begin
			status      = over ? tsd_pkg::ST_REPORTED : tsd_pkg::ST_UNCHANGED;
			temperature = dec;
		end
		reported_temperature = report ? dec : last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 16'h0000;
		end else if (commit && report) begin
			last_q <= dec;
		end
	end

endmodule

// File: rtl/thermometer_scratchpad_decoder_unit.sv
// ----------------------------------------------------------------------------
// thermometer_scratchpad_decoder_unit
// one-wire thermometer scratchpad checker and temperature change reporter
// ----------------------------------------------------------------------------
// usage:
//   s_* takes one scratchpad byte per transaction, s_tuser marks byte 0 of a
//   new read and restarts the byte count and the crc
//   bytes 0..7 run through the crc-8, byte 8 is compared against it; only the
//   transaction carrying byte 8 gives a result on m_*, bytes past 8 are
//   dropped until the next start mark
//   m_* carries status, decoded temperature and the last reported value
//   cfg_we/cfg_index/cfg_data write sensor family and change threshold, to
//   be done while no frame byte is in flight
// timing:
//   one input register, then crc/decode/threshold logic, then the result
//   register; byte 8's result is loaded as the byte leaves the input stage
//   one byte per cycle sustained unless a held result stalls a byte 8
// reset:
//   arst_n clears count, crc, last reported value (to 0) and the registers
//   (family 0, threshold 8); no stages hold valid data afterward
// stall:
//   with m_tready low the result register holds; bytes that give no result
//   keep flowing, a byte 8 waits in the input stage and s_tready drops
// ----------------------------------------------------------------------------
module thermometer_scratchpad_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	// result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [1:0] status, [17:2] temperature,
	                               // [33:18] reported_temperature, [39:34] zero
);

	// configuration registers
	logic       family_q;
	logic [7:0] threshold_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// result register
	logic        m_valid_q;
	logic [39:0] m_data_q;

	tsd_pkg::frame_t   frame;
	logic              s1_go;
	logic              out_free;
	logic [1:0]        status;
	logic signed [15:0] temperature;
	logic signed [15:0] reported_temperature;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			family_q    <= 1'b0;
			threshold_q <= tsd_pkg::THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsd_pkg::CFG_FAMILY:    family_q    <= cfg_data[0];
				tsd_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
			endcase
		end
	end

	// the output slot is free when empty or being emptied this cycle
	assign out_free = !m_valid_q || m_tready;
	// a byte with no result never waits on the output side
	assign s1_go    = valid_s1 && (!frame.result || out_free);
	assign s_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	tsd_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (s1_go),
		.data_byte   (byte_s1),
		.frame_start (start_s1),
		.frame       (frame)
	);

	tsd_decode u_decode (
		.clk                  (clk),
		.arst_n               (arst_n),
		.commit               (s1_go && frame.result),
		.frame                (frame),
		.sensor_family        (family_q),
		.change_threshold     (threshold_q),
		.status               (status),
		.temperature          (temperature),
		.reported_temperature (reported_temperature)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_go && frame.result) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && frame.result) begin
			m_data_q <= {6'd0, reported_temperature, temperature, status};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// a crc failure never carries a temperature
	a_crc_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == tsd_pkg::ST_CRC_ERR) |-> (m_tdata[17:2] == 16'h0000))
		else $error("crc error result with nonzero temperature");

	// a reported result updates the stored value to the new temperature
	a_report_match : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1:0] == tsd_pkg::ST_REPORTED) |-> (m_tdata[33:18] == m_tdata[17:2]))
		else $error("reported value differs from decoded temperature");

	// input backpressure only comes from a full result register
	a_ready_cause : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

	// a fresh result follows a handled byte 8 in the input stage
	a_result_source : assert property (@(posedge clk) disable iff (!arst_n)
		($rose(m_tvalid)) |-> $past(valid_s1 && frame.result))
		else $error("result appeared without a final frame byte");

endmodule

// File: tb/sv/tb_thermometer_scratchpad_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_thermometer_scratchpad_decoder_unit
// self-checking bench for the scratchpad crc check and temperature reporter
// ----------------------------------------------------------------------------
// scratchpad bytes go in on s_*, one byte per transaction
// in-order scoreboard tracks byte count, crc, decode and threshold state,
// one expected report queued per byte 8
// each m_* transaction checked field by field against the oldest report
// a few hand-built reads first, then segments of random frames, short
// frames, trailing bytes and line noise
// each segment with its own family and threshold; idle and stall rates repeat
// one segment holds the receiver off long enough to back the block up
// ----------------------------------------------------------------------------
module tb_thermometer_scratchpad_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected report, as it should appear on m_tdata
	typedef struct {
		bit [1:0]  status;
		bit [15:0] temperature;
		bit [15:0] reported;
	} report_t;

	// in-order model of the decoder plus the queue of reports still owed
	class report_scoreboard;
		bit          family;
		bit [7:0]    threshold;
		int unsigned fill;
		bit [7:0]    crc;
		bit [7:0]    pad [tsd_pkg::FRAME_LEN];
		bit [15:0]   last_rep;
		report_t     pending_reports [$];
		int          errors;

		function new();
			family    = 1'b0;
			threshold = tsd_pkg::THRESHOLD_RESET;
			fill      = 0;
			crc       = '0;
			last_rep  = '0;
			errors    = 0;
		endfunction

		// reflected crc-8, data folded in first, then eight lsb-first shifts
		static function bit [7:0] crc_step(bit [7:0] c, bit [7:0] d);
			bit [7:0] r;
			r = c ^ d;
			for (int k = 0; k < 8; k++) begin
				r = r[0] ? ((r >> 1) ^ tsd_pkg::CRC_POLY) : (r >> 1);
			end
			return r;
		endfunction

		function void set_reg(logic idx, bit [7:0] value);
			if (idx == tsd_pkg::CFG_FAMILY) begin
				family = value[0];
			end else begin
				threshold = value;
			end
		endfunction

		// raw reading from bytes 0 and 1, refined per sensor family
		function bit [15:0] decode_reading();
			bit [15:0] raw;
			raw = {pad[1], pad[0]};
			if (family) begin
				raw = raw << 3;
				if (pad[7] == tsd_pkg::EXT_COUNT) begin
					raw = (raw & tsd_pkg::EXT_MASK) + tsd_pkg::EXT_BASE - {8'h00, pad[6]};
				end
			end else begin
				unique case (pad[4][6:5])
					tsd_pkg::RES_9BIT:  raw[2:0] = '0;
					tsd_pkg::RES_10BIT: raw[1:0] = '0;
					tsd_pkg::RES_11BIT: raw[0]   = 1'b0;
					tsd_pkg::RES_12BIT: ;
				endcase
			end
			return raw;
		endfunction

		// one accepted byte; returns 1 when the byte counted toward a frame
		function bit note_byte(bit [7:0] d, bit start);
			int unsigned idx;
			report_t     r;
			bit [15:0]   t;
			int          diff;
			if (start) begin
				fill = 0;
				crc  = '0;
			end
			if (fill >= tsd_pkg::FRAME_LEN) begin
				return 1'b0;
			end
			idx      = fill;
			pad[idx] = d;
			fill     = idx + 1;
			if (idx < tsd_pkg::CRC_LEN) begin
				crc = crc_step(crc, d);
				return 1'b1;
			end
			if (crc != d) begin
				r.status      = tsd_pkg::ST_CRC_ERR;
				r.temperature = '0;
				r.reported    = last_rep;
			end else begin
				t    = decode_reading();
				diff = int'(shortint'(t)) - int'(shortint'(last_rep));
				if (diff < 0) begin
					diff = -diff;
				end
				r.status = tsd_pkg::ST_UNCHANGED;
				// strictly greater than the threshold
				if (diff > int'(threshold)) begin
					last_rep = t;
					r.status = tsd_pkg::ST_REPORTED;
				end
				r.temperature = t;
				r.reported    = last_rep;
			end
			pending_reports.push_back(r);
			return 1'b1;
		endfunction

		function void check_report(logic [39:0] data);
			report_t r;
			if (pending_reports.size() == 0) begin
				$error("report with none pending: data %h", data);
				errors++;
				return;
			end
			r = pending_reports.pop_front();
			if (data[1:0] !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, data[1:0]);
				errors++;
			end
			if (data[17:2] !== r.temperature) begin
				$error("temperature: expected %0d, got %0d",
				       shortint'(r.temperature), shortint'(data[17:2]));
				errors++;
			end
			if (data[33:18] !== r.reported) begin
				$error("reported_temperature: expected %0d, got %0d",
				       shortint'(r.reported), shortint'(data[33:18]));
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic        cfg_index = tsd_pkg::CFG_FAMILY;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
	logic        s_tuser  = 1'b0; // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [1:0] status, [17:2] temperature,
	                              // [33:18] reported_temperature, [39:34] zero

	report_scoreboard sb = new();

	int send_idle_pct  = 0;   // chance of a sender gap per cycle, percent
	int stall_pct      = 0;   // chance of m_tready low per cycle, percent
	int hold_left      = 0;   // cycles of forced receiver hold-off still to go
	int consumed_bytes = 0;   // bytes the frame logic took in this segment

	thermometer_scratchpad_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result monitor, values sampled as they stood before this edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_report(m_tdata);
		end
	end

	// one byte transaction; valid stays high afterward unless a gap follows
	task automatic send_byte(input bit [7:0] d, input bit start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		if (sb.note_byte(d, start)) begin
			consumed_bytes++;
		end
	endtask

	// both registers written on back-to-back edges, enable dropped once after
	task automatic configure(input bit family, input bit [7:0] threshold);
		cfg_we    <= 1'b1;
		cfg_index <= tsd_pkg::CFG_FAMILY;
		cfg_data  <= {7'b0, family};
		@(posedge clk);
		sb.set_reg(tsd_pkg::CFG_FAMILY, {7'b0, family});
		cfg_index <= tsd_pkg::CFG_THRESHOLD;
		cfg_data  <= threshold;
		@(posedge clk);
		sb.set_reg(tsd_pkg::CFG_THRESHOLD, threshold);
		cfg_we <= 1'b0;
	endtask

	// stop sending, wait for every owed report, then let the pipe empty
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_reports.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	function automatic bit [7:0] frame_crc(input bit [7:0] pad [tsd_pkg::FRAME_LEN]);
		bit [7:0] c;
		c = '0;
		for (int k = 0; k < tsd_pkg::CRC_LEN; k++) begin
			c = report_scoreboard::crc_step(c, pad[k]);
		end
		return c;
	endfunction

	task automatic send_directed();
		bit [7:0] pad [tsd_pkg::FRAME_LEN];
		// first read after reset with no start mark, 12-bit resolution
		pad    = '{8'h91, 8'h01, 8'h4B, 8'h46, 8'h7F, 8'h00, 8'h0C, 8'h10, 8'h00};
		pad[8] = frame_crc(pad);
		for (int k = 0; k < tsd_pkg::FRAME_LEN; k++) begin
			send_byte(pad[k], 1'b0);
		end
		// byte past the end of the read, dropped
		send_byte(8'hFF, 1'b0);
		// all-ones reading at 9-bit resolution, masked to -8
		pad    = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h1F, 8'hFF, 8'hFF, 8'h10, 8'h00};
		pad[8] = frame_crc(pad);
		for (int k = 0; k < tsd_pkg::FRAME_LEN; k++) begin
			send_byte(pad[k], k == 0);
		end
		// same read with a broken crc byte
		pad[8] = ~pad[8];
		for (int k = 0; k < tsd_pkg::FRAME_LEN; k++) begin
			send_byte(pad[k], k == 0);
		end
	endtask

	// one random piece of traffic: a read, a cut-short read, or noise
	task automatic send_scratchpad();
		bit [7:0]  pad [tsd_pkg::FRAME_LEN];
		bit [15:0] t;
		int        kind;
		int        len;
		int        delta;
		int        count_remain;
		kind = $urandom_range(99);
		if (kind >= 92) begin
			// line noise: random bytes with random start marks
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom), 1'($urandom_range(1)));
			return;
		end
		foreach (pad[k]) begin
			pad[k] = 8'($urandom);
		end
		if ($urandom_range(1)) begin
			pad[7] = tsd_pkg::EXT_COUNT;
		end
		case ($urandom_range(2))
			0: ; // raw reading fully random
			1: begin
				// land exactly at or one past the threshold from the last report
				delta = int'(sb.threshold) + int'($urandom_range(1));
				if ($urandom_range(1)) begin
					delta = -delta;
				end
				if (!sb.family) begin
					t      = sb.last_rep + 16'(delta);
					pad[0] = t[7:0];
					pad[1] = t[15:8];
					pad[4] = pad[4] | 8'h60;
				end else begin
					// extended count: result is aligned raw + 12 - count_remain
					t            = sb.last_rep & tsd_pkg::EXT_MASK;
					count_remain = int'(tsd_pkg::EXT_BASE) + int'(t) - int'(sb.last_rep)
					               - delta;
					if (count_remain >= 0 && count_remain <= 255) begin
						t      = t >> 3;
						pad[0] = t[7:0];
						pad[1] = t[15:8];
						pad[6] = 8'(count_remain);
						pad[7] = tsd_pkg::EXT_COUNT;
					end
				end
			end
			default: begin
				// plausible reading, -55 to +125 degrees
				t = 16'($urandom_range(2880)) - 16'd880;
				if (sb.family) begin
					t = {{3{t[15]}}, t[15:3]};
				end
				pad[0] = t[7:0];
				pad[1] = t[15:8];
			end
		endcase
		pad[8] = frame_crc(pad);
		if (kind < 12) begin
			pad[8] = pad[8] ^ 8'($urandom_range(1, 255));
		end
		len = tsd_pkg::FRAME_LEN;
		if (kind >= 12 && kind < 22) begin
			// read cut short, the next start mark restarts it
			len = $urandom_range(1, tsd_pkg::FRAME_LEN - 1);
		end
		for (int k = 0; k < len; k++) begin
			send_byte(pad[k], k == 0);
		end
		if (kind >= 82) begin
			// trailing bytes without a start mark, all dropped
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
		end
	endtask

	initial begin
		bit       seg_family [7];
		bit [7:0] seg_threshold [7];
		int       idle_tbl [4];
		int       stall_tbl [4];
		seg_family    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		seg_threshold = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd8, 8'd1, 8'd17};
		idle_tbl      = '{0, 78, 0, 35};
		stall_tbl     = '{0, 0, 78, 35};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed reads under reset register values
		send_directed();
		drain();

		for (int seg = 0; seg < 7; seg++) begin
			configure(seg_family[seg], seg_threshold[seg]);
			send_idle_pct  = idle_tbl[seg % 4];
			stall_pct      = stall_tbl[seg % 4];
			consumed_bytes = 0;
			if (seg == 2) begin
				// long receiver hold-off while the sender keeps offering bytes
				hold_left = 300;
			end
			while (consumed_bytes < 150) begin
				send_scratchpad();
			end
			drain();
		end

		if (sb.errors == 0 && sb.pending_reports.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
